>>> rtl/core/random_burst_pulse_timer_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the random burst pulse timer
// Shared property forms. Each use expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef RANDOM_BURST_PULSE_TIMER_UNIT_MACROS_SVH
`define RANDOM_BURST_PULSE_TIMER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBPT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RBPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rbpt_pkg.sv
// ----------------------------------------------------------------------------
// rbpt_pkg
// Types, constants and helper functions of the random burst pulse timer.
// ----------------------------------------------------------------------------
package rbpt_pkg;

    // Phase of the output loop.
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ON   = 3'd1,
        PH_BOFF = 3'd2,
        PH_BON  = 3'd3,
        PH_LOFF = 3'd4
    } phase_t;

    // Which random draw is in progress.
    typedef enum logic [2:0] {
        DRAW_ON,
        DRAW_BCNT,
        DRAW_BOFF,
        DRAW_BON,
        DRAW_LOFF
    } draw_sel_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_ON_MIN          = 3'd0,
        CFG_ON_MAX          = 3'd1,
        CFG_BURST_LIMIT     = 3'd2,
        CFG_BURST_COUNT_MAX = 3'd3,
        CFG_BURST_OFF_MAX   = 3'd4,
        CFG_BURST_ON_MAX    = 3'd5,
        CFG_OFF_MIN         = 3'd6,
        CFG_OFF_MAX         = 3'd7
    } cfg_index_t;

    // Input command codes.
    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_SEED = 1'b1
    } command_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_RAND,
        S_DIV,
        S_APPLY,
        S_FINISH
    } ctrl_state_t;

    localparam logic [31:0] GEN_RESET = 32'h1234_5678;
    localparam logic [31:0] ZERO_SEED = 32'hCAFE_BABE;

    localparam logic [7:0]  ON_MIN_RST          = 8'd2;
    localparam logic [7:0]  ON_MAX_RST          = 8'd30;
    localparam logic [7:0]  BURST_LIMIT_RST     = 8'd7;
    localparam logic [3:0]  BURST_COUNT_MAX_RST = 4'd4;
    localparam logic [7:0]  BURST_OFF_MAX_RST   = 8'd5;
    localparam logic [7:0]  BURST_ON_MAX_RST    = 8'd7;
    localparam logic [15:0] OFF_MIN_RST         = 16'd180;
    localparam logic [15:0] OFF_MAX_RST         = 16'd780;

    // Fixed lower bounds of the burst draws.
    localparam logic [15:0] BURST_LO     = 16'd1;
    localparam logic [15:0] BURST_ON_LO  = 16'd2;

    // Restoring divider: one quotient bit per cycle over a 32-bit dividend.
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load_item;
        logic      seed_load;
        logic      reseed;
        logic      decrement;
        logic      burst_dec;
        logic      rand_step;
        logic      div_step;
        logic      apply;
        logic      out_load;
        draw_sel_t draw_sel;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic   is_seed;
        phase_t phase;
        logic   remaining_gt1;
        logic   burst_ok;
        logic   burst_more;
        logic   div_last;
        logic   out_valid;
    } dp_status_t;

    // One xorshift32 step.
    function automatic logic [31:0] xorshift32(input logic [31:0] s);
        logic [31:0] x;
        begin
            x = s;
            x = x ^ (x << 13);
            x = x ^ (x >> 17);
            x = x ^ (x << 5);
            return x;
        end
    endfunction

    // A zero seed would lock the generator, so it is replaced.
    function automatic logic [31:0] fix_seed(input logic [31:0] s);
        return (s == 32'd0) ? ZERO_SEED : s;
    endfunction

endpackage

>>> rtl/core/rbpt_datapath.sv
// ----------------------------------------------------------------------------
// rbpt_datapath
// Configuration, generator, phase state, serial modulo unit and result register.
// ----------------------------------------------------------------------------
`include "random_burst_pulse_timer_unit_macros.svh"

module rbpt_datapath
    import rbpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        in_command,
    input  logic [31:0] in_seed,
    input  logic [15:0] in_jitter,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic        out_ready,
    output logic        out_valid,
    output logic        out_pin_level,
    output logic [2:0]  out_phase,
    output logic [15:0] out_seconds_left,
    output logic [3:0]  out_bursts_left
);

    // Configuration registers.
    logic [7:0]  on_min_reg, on_max_reg, burst_limit_reg;
    logic [3:0]  burst_count_max_reg;
    logic [7:0]  burst_off_max_reg, burst_on_max_reg;
    logic [15:0] off_min_reg, off_max_reg;

    // Captured input item.
    logic        command_reg;
    logic [31:0] seed_reg;
    logic [15:0] jitter_reg;

    // Loop state.
    logic [31:0] gen_reg, gen_next;
    phase_t      phase_reg;
    logic [15:0] remaining_reg;
    logic [3:0]  burst_reg;
    logic [7:0]  on_len_reg;

    // Draw and modulo unit.
    logic [15:0]          lo_reg;
    logic [16:0]          span_reg;
    logic [31:0]          dividend_reg;
    logic [15:0]          rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    // Result register.
    logic        out_valid_reg;
    logic        out_pin_reg;
    phase_t      out_phase_reg;
    logic [15:0] out_seconds_reg;
    logic [3:0]  out_bursts_reg;

    logic [15:0] lo_sel, hi_sel;
    logic [16:0] span_calc;
    logic [16:0] trial;
    logic [16:0] draw_val;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_min_reg          <= ON_MIN_RST;
            on_max_reg          <= ON_MAX_RST;
            burst_limit_reg     <= BURST_LIMIT_RST;
            burst_count_max_reg <= BURST_COUNT_MAX_RST;
            burst_off_max_reg   <= BURST_OFF_MAX_RST;
            burst_on_max_reg    <= BURST_ON_MAX_RST;
            off_min_reg         <= OFF_MIN_RST;
            off_max_reg         <= OFF_MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_ON_MIN:          on_min_reg          <= cfg_wdata[7:0];
                CFG_ON_MAX:          on_max_reg          <= cfg_wdata[7:0];
                CFG_BURST_LIMIT:     burst_limit_reg     <= cfg_wdata[7:0];
                CFG_BURST_COUNT_MAX: burst_count_max_reg <= cfg_wdata[3:0];
                CFG_BURST_OFF_MAX:   burst_off_max_reg   <= cfg_wdata[7:0];
                CFG_BURST_ON_MAX:    burst_on_max_reg    <= cfg_wdata[7:0];
                CFG_OFF_MIN:         off_min_reg         <= cfg_wdata;
                CFG_OFF_MAX:         off_max_reg         <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Capture the accepted item.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            command_reg <= in_command;
            seed_reg    <= in_seed;
            jitter_reg  <= in_jitter;
        end
    end

    // Bounds of the selected draw and its span; a max below its min gives span one.
    always_comb
    begin
        lo_sel = 16'd0;
        hi_sel = 16'd0;
        case (cmd.draw_sel)
            DRAW_ON:
            begin
                lo_sel = {8'd0, on_min_reg};
                hi_sel = {8'd0, on_max_reg};
            end
            DRAW_BCNT:
            begin
                lo_sel = BURST_LO;
                hi_sel = {12'd0, burst_count_max_reg};
            end
            DRAW_BOFF:
            begin
                lo_sel = BURST_LO;
                hi_sel = {8'd0, burst_off_max_reg};
            end
            DRAW_BON:
            begin
                lo_sel = BURST_ON_LO;
                hi_sel = {8'd0, burst_on_max_reg};
            end
            DRAW_LOFF:
            begin
                lo_sel = off_min_reg;
                hi_sel = off_max_reg;
            end
            default: ;
        endcase
        span_calc = (hi_sel >= lo_sel) ? ({1'b0, hi_sel} - {1'b0, lo_sel} + 17'd1) : 17'd1;
    end

    // Generator next value.
    always_comb
    begin
        gen_next = gen_reg;
        if (cmd.seed_load)
            gen_next = fix_seed(seed_reg);
        else if (cmd.reseed)
            gen_next = fix_seed(gen_reg ^ {16'd0, jitter_reg});
        else if (cmd.rand_step)
            gen_next = xorshift32(gen_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gen_reg <= GEN_RESET;
        else
            gen_reg <= gen_next;
    end

    // Restoring modulo: shift in one dividend bit, subtract the span if it fits.
    assign trial = {rem_reg, dividend_reg[31]};

    always_ff @(posedge clk)
    begin
        if (cmd.rand_step)
        begin
            lo_reg       <= lo_sel;
            span_reg     <= span_calc;
            dividend_reg <= gen_next;
            rem_reg      <= 16'd0;
            div_cnt_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            if (trial >= span_reg)
                rem_reg <= 16'(trial - span_reg);
            else
                rem_reg <= trial[15:0];
            dividend_reg <= {dividend_reg[30:0], 1'b0};
            div_cnt_reg  <= div_cnt_reg + 1'b1;
        end
    end

    assign draw_val = {1'b0, lo_reg} + {1'b0, rem_reg};

    // Phase, remaining time, burst count and on length.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            remaining_reg <= 16'd0;
            burst_reg     <= 4'd0;
            on_len_reg    <= 8'd0;
        end
        else if (cmd.decrement)
        begin
            remaining_reg <= remaining_reg - 16'd1;
        end
        else if (cmd.burst_dec)
        begin
            burst_reg <= (burst_reg != 4'd0) ? burst_reg - 4'd1 : 4'd0;
        end
        else if (cmd.apply)
        begin
            case (cmd.draw_sel)
                DRAW_ON:
                begin
                    phase_reg     <= PH_ON;
                    on_len_reg    <= draw_val[7:0];
                    remaining_reg <= {8'd0, draw_val[7:0]};
                    burst_reg     <= 4'd0;
                end
                DRAW_BCNT:
                    burst_reg <= draw_val[3:0];
                DRAW_BOFF:
                begin
                    phase_reg     <= PH_BOFF;
                    remaining_reg <= draw_val[15:0];
                end
                DRAW_BON:
                begin
                    phase_reg     <= PH_BON;
                    remaining_reg <= draw_val[15:0];
                end
                DRAW_LOFF:
                begin
                    phase_reg     <= PH_LOFF;
                    remaining_reg <= draw_val[15:0];
                    burst_reg     <= 4'd0;
                end
                default: ;
            endcase
        end
    end

    // Result register: filled at the end of an item, emptied by a transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_pin_reg     <= (phase_reg == PH_ON) || (phase_reg == PH_BON);
            out_phase_reg   <= phase_reg;
            out_seconds_reg <= remaining_reg;
            out_bursts_reg  <= burst_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_pin_level    = out_pin_reg;
    assign out_phase        = out_phase_reg;
    assign out_seconds_left = out_seconds_reg;
    assign out_bursts_left  = out_bursts_reg;

    // Status toward the controller.
    assign status.is_seed       = (command_t'(command_reg) == CMD_SEED);
    assign status.phase         = phase_reg;
    assign status.remaining_gt1 = (remaining_reg > 16'd1);
    assign status.burst_ok      = (on_len_reg > 8'd2) && (on_len_reg < burst_limit_reg);
    assign status.burst_more    = (burst_reg > 4'd1);
    assign status.div_last      = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign status.out_valid     = out_valid_reg;

    // Once the loop leaves idle it never returns; idle always shows zeros.
    `RBPT_ASSERT_SAME(a_idle_zero, phase_reg == PH_IDLE, (remaining_reg == 16'd0) && (burst_reg == 4'd0), "idle phase with nonzero counters")
    // A main on phase always starts with its own drawn length.
    `RBPT_ASSERT_NEXT(a_on_len, cmd.apply && (cmd.draw_sel == DRAW_ON), remaining_reg == {8'd0, on_len_reg}, "on phase length mismatch")
    // A loaded result is never lost before it is transferred.
    `RBPT_ASSERT_SAME(a_no_overwrite, cmd.out_load, !out_valid_reg || out_ready, "result register overwritten")

endmodule

>>> rtl/core/rbpt_controller.sv
// ----------------------------------------------------------------------------
// rbpt_controller
// Sequencer that steps the datapath through one item: decide, draw, apply.
// ----------------------------------------------------------------------------
`include "random_burst_pulse_timer_unit_macros.svh"

module rbpt_controller
    import rbpt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    draw_sel_t   sel_reg, sel_next;

    // State and draw selection registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= DRAW_ON;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        cmd          = '0;
        cmd.draw_sel = sel_reg;
        in_ready     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EVAL;
                end
            end

            S_EVAL:
            begin
                if (status.is_seed)
                begin
                    cmd.seed_load = 1'b1;
                    sel_next      = DRAW_ON;
                    state_next    = S_RAND;
                end
                else if (status.phase == PH_IDLE)
                begin
                    state_next = S_FINISH;
                end
                else if (status.remaining_gt1)
                begin
                    cmd.decrement = 1'b1;
                    state_next    = S_FINISH;
                end
                else
                begin
                    state_next = S_RAND;
                    unique case (status.phase)
                        PH_ON:
                            sel_next = status.burst_ok ? DRAW_BCNT : DRAW_LOFF;
                        PH_BOFF:
                            sel_next = DRAW_BON;
                        PH_BON:
                        begin
                            cmd.burst_dec = 1'b1;
                            sel_next      = status.burst_more ? DRAW_BOFF : DRAW_LOFF;
                        end
                        PH_LOFF:
                        begin
                            cmd.reseed = 1'b1;
                            sel_next   = DRAW_ON;
                        end
                        default:
                            state_next = S_FINISH;
                    endcase
                end
            end

            S_RAND:
            begin
                cmd.rand_step = 1'b1;
                state_next    = S_DIV;
            end

            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = S_APPLY;
            end

            S_APPLY:
            begin
                cmd.apply = 1'b1;
                // A burst count draw is followed at once by the first burst off draw.
                if (sel_reg == DRAW_BCNT)
                begin
                    sel_next   = DRAW_BOFF;
                    state_next = S_RAND;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (!status.out_valid || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // An accepted transfer is always evaluated in the following cycle.
    `RBPT_ASSERT_NEXT(a_accept_eval, in_valid && in_ready, state_reg == S_EVAL, "accepted item not evaluated")
    // The apply step only follows the last modulo iteration.
    `RBPT_ASSERT_NEXT(a_div_apply, (state_reg == S_DIV) && status.div_last, state_reg == S_APPLY, "modulo did not end in apply")
    // After a burst count draw, the next draw is always the burst off length.
    `RBPT_ASSERT_NEXT(a_bcnt_boff, (state_reg == S_APPLY) && (sel_reg == DRAW_BCNT), (state_reg == S_RAND) && (sel_reg == DRAW_BOFF), "burst count not followed by burst off draw")

endmodule

>>> rtl/core/random_burst_pulse_timer_unit.sv
// A countdown tick that ends no phase needs no draw; a tick or seed that draws a length runs
// one draw, and a phase end that starts a burst draws twice. Each draw is one xorshift step
// and a serial restoring modulo over the 32-bit generator value.
// Throughput: one item at a time; the next item is taken the cycle after the result is
// registered, while that result still waits for its transfer out.
// Reset: asynchronous active low; configuration returns to its defaults, loop to idle.
// ----------------------------------------------------------------------------
// random_burst_pulse_timer_unit
// Pulse timer stepped by one-second ticks, with randomly drawn on, burst and off phases.
// ----------------------------------------------------------------------------
module random_burst_pulse_timer_unit
    import rbpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // seed_value[31:0], jitter[47:32]
    input  logic        s_axis_tuser,   // command[0]
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // pin_level[0], phase[3:1], seconds_left[19:4],
                                        // bursts_left[23:20]
);

    dp_cmd_t    cmd;
    dp_status_t status;

    logic        pin_level;
    logic [2:0]  phase;
    logic [15:0] seconds_left;
    logic [3:0]  bursts_left;

    rbpt_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    rbpt_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .in_command       (s_axis_tuser),
        .in_seed          (s_axis_tdata[31:0]),
        .in_jitter        (s_axis_tdata[47:32]),
        .cmd              (cmd),
        .status           (status),
        .out_ready        (m_axis_tready),
        .out_valid        (m_axis_tvalid),
        .out_pin_level    (pin_level),
        .out_phase        (phase),
        .out_seconds_left (seconds_left),
        .out_bursts_left  (bursts_left)
    );

    // Pack the result fields, lowest field first.
    assign m_axis_tdata = {bursts_left, seconds_left, phase, pin_level};

endmodule
